// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the parity sorted set.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is held.
`define PSI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Check an overlapping implication on every rising edge outside reset.
`define PSI_ASSERT_IMPL(lbl, ante, cons) \
  `PSI_ASSERT(lbl, (ante) |-> (cons))

`endif

// ===== hw/rtl/psi_pkg.sv =====
// Package for the parity sorted set: default sizes, request and status
// codes, controller state type and the cell control struct. No dependencies.
package psi_pkg;

  localparam int PSI_CAPACITY = 64;
  localparam int PSI_KEY_BITS = 31;

  typedef enum logic [1:0] {
    REQ_INSERT        = 2'd0,
    REQ_INSERT_UNIQUE = 2'd1,
    REQ_READ          = 2'd2,
    REQ_CLEAR         = 2'd3
  } psi_req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_RANGE     = 2'd3
  } psi_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } psi_state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic cmp;  // register the compare flags
    logic ins;  // shift and insert the key
  } psi_cell_ctl_t;

endpackage

// ===== hw/rtl/psi_if.sv =====
// Request and response channel interfaces of the parity sorted set.
// Valid/ready handshake; sizes default to the psi_pkg constants.
interface psi_req_if #(
  parameter int KEY_W = psi_pkg::PSI_KEY_BITS,
  parameter int POS_W = $clog2(psi_pkg::PSI_CAPACITY)
);
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [KEY_W-1:0] key;
  logic [POS_W-1:0] position;

  modport source (output valid, req_type, key, position, input ready);
  modport sink   (input valid, req_type, key, position, output ready);
endinterface

interface psi_rsp_if #(
  parameter int KEY_W = psi_pkg::PSI_KEY_BITS,
  parameter int CNT_W = $clog2(psi_pkg::PSI_CAPACITY + 1)
);
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [KEY_W-1:0] read_key;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] even_count;

  modport source (output valid, status, read_key, entry_count, even_count, input ready);
  modport sink   (input valid, status, read_key, entry_count, even_count, output ready);
endinterface

// ===== hw/rtl/psi_cell.sv =====
// One table entry of the parity sorted set with its compare flags.
// Depends on psi_pkg for the control struct; chained to its lower neighbour.
module psi_cell #(
  parameter int KEY_W = psi_pkg::PSI_KEY_BITS,
  parameter int CNT_W = $clog2(psi_pkg::PSI_CAPACITY + 1),
  parameter int POS_W = $clog2(psi_pkg::PSI_CAPACITY),
  parameter int IDX   = 0
) (
  input  logic                  clk,
  input  psi_pkg::psi_cell_ctl_t ctl,
  input  logic [KEY_W-1:0]      key,
  input  logic [CNT_W-1:0]      lo,
  input  logic [CNT_W-1:0]      hi,
  input  logic [POS_W-1:0]      position,
  input  logic [KEY_W-1:0]      prev_entry,
  input  logic                  prev_ahead,
  output logic [KEY_W-1:0]      entry,
  output logic                  ahead,
  output logic                  match,
  output logic [KEY_W-1:0]      rd_key
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);
  localparam logic [POS_W-1:0] IDX_P = POS_W'(IDX);

  logic [KEY_W-1:0] entry_r;
  logic             ahead_r;
  logic             match_r;
  logic             in_region;

  assign in_region = (IDX_C >= lo) && (IDX_C < hi);

  // Register the compare flags: the entry stays ahead of the new key, or equals it.
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      ahead_r <= (IDX_C < lo) || (in_region && (entry_r <= key));
      match_r <= in_region && (entry_r == key);
    end
  end

  // Shift: take the key where the neighbour stays ahead, else the neighbour's entry.
  always_ff @(posedge clk) begin
    if (ctl.ins && !ahead_r) begin
      entry_r <= prev_ahead ? key : prev_entry;
    end
  end

  assign entry  = entry_r;
  assign ahead  = ahead_r;
  assign match  = match_r;
  assign rd_key = (position == IDX_P) ? entry_r : '0;

endmodule

// ===== hw/rtl/psi_ctrl.sv =====
// Sequencer of the parity sorted set: request capture, counts, decision
// and output register. Depends on psi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module psi_ctrl #(
  parameter int CAPACITY = psi_pkg::PSI_CAPACITY,
  parameter int KEY_W    = psi_pkg::PSI_KEY_BITS,
  parameter int CNT_W    = $clog2(CAPACITY + 1),
  parameter int POS_W    = $clog2(CAPACITY)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_req_type,
  input  logic [KEY_W-1:0]       in_key,
  input  logic [POS_W-1:0]       in_position,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_status,
  output logic [KEY_W-1:0]       out_read_key,
  output logic [CNT_W-1:0]       out_entry_count,
  output logic [CNT_W-1:0]       out_even_count,
  output psi_pkg::psi_cell_ctl_t cell_ctl,
  output logic [KEY_W-1:0]       cell_key,
  output logic [CNT_W-1:0]       cell_lo,
  output logic [CNT_W-1:0]       cell_hi,
  output logic [POS_W-1:0]       cell_pos,
  input  logic                   any_match,
  input  logic [KEY_W-1:0]       sel_key
);

  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  psi_pkg::psi_state_t state_r, state_nxt;
  psi_pkg::psi_req_t   req_r;
  logic [KEY_W-1:0]    key_r;
  logic [POS_W-1:0]    pos_r;
  logic [CNT_W-1:0]    tot_r, tot_nxt;
  logic [CNT_W-1:0]    evn_r, evn_nxt;
  logic                out_valid_r;
  logic [1:0]          status_r;
  logic [KEY_W-1:0]    rkey_r;
  logic [CNT_W-1:0]    ocnt_r;
  logic [CNT_W-1:0]    oevn_r;

  psi_pkg::psi_status_t status_c;
  logic [KEY_W-1:0]     rkey_c;
  logic                 do_ins;
  logic                 out_free;
  logic                 key_even;
  logic                 full;
  logic                 exec_go;

  assign out_free = !out_valid_r || out_ready;
  assign key_even = !key_r[0];
  assign full     = (tot_r >= CAP_C);
  assign exec_go  = (state_r == psi_pkg::S_EXEC) && out_free;

  // Next state: capture, compare, then decide once the output register is free.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psi_pkg::S_IDLE: if (in_valid) state_nxt = psi_pkg::S_CMP;
      psi_pkg::S_CMP:  state_nxt = psi_pkg::S_EXEC;
      psi_pkg::S_EXEC: if (out_free) state_nxt = psi_pkg::S_IDLE;
      default:         state_nxt = psi_pkg::S_IDLE;
    endcase
  end

  // Decide the request outcome from the registered cell flags.
  always_comb begin
    status_c = psi_pkg::ST_OK;
    rkey_c   = '0;
    do_ins   = 1'b0;
    tot_nxt  = tot_r;
    evn_nxt  = evn_r;
    case (req_r)
      psi_pkg::REQ_INSERT, psi_pkg::REQ_INSERT_UNIQUE: begin
        if ((req_r == psi_pkg::REQ_INSERT_UNIQUE) && any_match) begin
          status_c = psi_pkg::ST_DUPLICATE;
        end else if (full) begin
          status_c = psi_pkg::ST_FULL;
        end else begin
          do_ins  = 1'b1;
          tot_nxt = tot_r + ONE_C;
          if (key_even) evn_nxt = evn_r + ONE_C;
        end
      end
      psi_pkg::REQ_READ: begin
        if (CNT_W'(pos_r) < tot_r) begin
          rkey_c = sel_key;
        end else begin
          status_c = psi_pkg::ST_RANGE;
        end
      end
      psi_pkg::REQ_CLEAR: begin
        tot_nxt = '0;
        evn_nxt = '0;
      end
      default: begin
        status_c = psi_pkg::ST_OK;
      end
    endcase
  end

  // Drive the cell row.
  always_comb begin
    cell_ctl.cmp = (state_r == psi_pkg::S_CMP);
    cell_ctl.ins = exec_go && do_ins;
    cell_key     = key_r;
    cell_pos     = pos_r;
    cell_lo      = key_even ? '0 : evn_r;
    cell_hi      = key_even ? evn_r : tot_r;
  end

  assign in_ready        = (state_r == psi_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_read_key    = rkey_r;
  assign out_entry_count = ocnt_r;
  assign out_even_count  = oevn_r;

  // Hold control state and counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psi_pkg::S_IDLE;
      tot_r       <= '0;
      evn_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_go) begin
        tot_r       <= tot_nxt;
        evn_r       <= evn_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the request and load the result.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= psi_pkg::psi_req_t'(in_req_type);
      key_r <= in_key;
      pos_r <= in_position;
    end
    if (exec_go) begin
      status_r <= status_c;
      rkey_r   <= rkey_c;
      ocnt_r   <= tot_nxt;
      oevn_r   <= evn_nxt;
    end
  end

  `PSI_ASSERT(a_even_le_total, evn_r <= tot_r)
  `PSI_ASSERT(a_total_le_cap, tot_r <= CAP_C)
  `PSI_ASSERT_IMPL(a_ins_in_exec, cell_ctl.ins, (state_r == psi_pkg::S_EXEC) && out_free)
  `PSI_ASSERT(a_ins_grows, cell_ctl.ins |=> (tot_r == $past(tot_r) + ONE_C))
  `PSI_ASSERT(a_accept_cmp, (in_valid && in_ready) |=> (state_r == psi_pkg::S_CMP))

endmodule

// ===== hw/rtl/parity_sorted_set_insert_core.sv =====
// Top level of the parity sorted set: sequencer plus a row of entry cells.
// Depends on psi_pkg, psi_if, psi_cell and psi_ctrl.
//
// Use: requests arrive on in_ch (req_type, key, position) and each one gives
// exactly one response on out_ch (status, read_key, entry_count, even_count).
// Even keys are held ascending ahead of odd keys, also ascending; a new key
// lands after any equal keys. Every cell compares its own entry with the key
// and, on insert, a cell not ahead takes the key or its lower neighbour's entry.
// Steps: the sequencer accepts a request, the cells register their compare
// flags, then the sequencer decides, shifts and registers the response. A new
// request is accepted only once the last one has passed the decide step.
// A response waiting in the output register does not block acceptance of
// the next request; a stalled receiver holds the sequencer before the shift
// step, so no response is lost or overwritten.
// Reset (rst_n low, synchronous) empties the table and drops any pending
// response. Entry contents are not cleared; only entries below the count
// are ever read.
module parity_sorted_set_insert_core #(
  parameter int CAPACITY = psi_pkg::PSI_CAPACITY,
  parameter int KEY_BITS = psi_pkg::PSI_KEY_BITS
) (
  input logic    clk,
  input logic    rst_n,
  psi_req_if.sink  in_ch,
  psi_rsp_if.source out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int POS_W = $clog2(CAPACITY);

  psi_pkg::psi_cell_ctl_t cell_ctl;
  logic [KEY_BITS-1:0]    cell_key;
  logic [CNT_W-1:0]       cell_lo;
  logic [CNT_W-1:0]       cell_hi;
  logic [POS_W-1:0]       cell_pos;
  logic                   any_match;
  logic [KEY_BITS-1:0]    sel_key;

  logic [KEY_BITS-1:0] entry  [CAPACITY];
  logic [KEY_BITS-1:0] rd_key [CAPACITY];
  logic [CAPACITY-1:0] ahead;
  logic [CAPACITY-1:0] match;

  psi_ctrl #(
    .CAPACITY (CAPACITY),
    .KEY_W    (KEY_BITS),
    .CNT_W    (CNT_W),
    .POS_W    (POS_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_req_type     (in_ch.req_type),
    .in_key          (in_ch.key),
    .in_position     (in_ch.position),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_read_key    (out_ch.read_key),
    .out_entry_count (out_ch.entry_count),
    .out_even_count  (out_ch.even_count),
    .cell_ctl        (cell_ctl),
    .cell_key        (cell_key),
    .cell_lo         (cell_lo),
    .cell_hi         (cell_hi),
    .cell_pos        (cell_pos),
    .any_match       (any_match),
    .sel_key         (sel_key)
  );

  // Build the cell row; the bottom cell sees a neighbour that always stays ahead.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0] nb_entry;
    logic                nb_ahead;
    if (i == 0) begin : g_first
      assign nb_entry = '0;
      assign nb_ahead = 1'b1;
    end else begin : g_rest
      assign nb_entry = entry[i-1];
      assign nb_ahead = ahead[i-1];
    end
    psi_cell #(
      .KEY_W (KEY_BITS),
      .CNT_W (CNT_W),
      .POS_W (POS_W),
      .IDX   (i)
    ) u_cell (
      .clk         (clk),
      .ctl         (cell_ctl),
      .key         (cell_key),
      .lo          (cell_lo),
      .hi          (cell_hi),
      .position    (cell_pos),
      .prev_entry  (nb_entry),
      .prev_ahead  (nb_ahead),
      .entry       (entry[i]),
      .ahead       (ahead[i]),
      .match       (match[i]),
      .rd_key      (rd_key[i])
    );
  end

  // Merge the presence flags and the one selected entry.
  assign any_match = |match;

  always_comb begin
    sel_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_key = sel_key | rd_key[i];
    end
  end

endmodule
